>>> hdl/rcbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcbe_pkg;

  // Direction store size; loco addresses at or above this are rejected
  localparam int LOCO_COUNT = 81;
  localparam int LOCO_IDX_W = (LOCO_COUNT > 1) ? $clog2(LOCO_COUNT) : 1;
  localparam logic [8:0] LOCO_LIMIT = 9'(LOCO_COUNT);

  // Speed scaling
  localparam logic [9:0] PERCENT_FULL = 10'd100;
  localparam logic [3:0] SPEED_MAX_STEP = 4'd14;

  // Command kinds on the input channel
  typedef enum logic [1:0] {
    OP_SWITCH   = 2'd0,
    OP_LOCO     = 2'd1,
    OP_FUNCTION = 2'd2,
    OP_POWER    = 2'd3
  } op_t;

  // Which byte the datapath puts on the output
  typedef enum logic [2:0] {
    SEL_SWITCH_CODE,
    SEL_SWITCH_ADDR,
    SEL_STOP,
    SEL_REVERSE,
    SEL_SPEED,
    SEL_ADDR,
    SEL_FUNCTION,
    SEL_POWER
  } byte_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      toggle;
    byte_sel_t sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic drop;
    logic need_rev;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/rcbe_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcbe_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [7:0]        address;
  logic [2:0]        port;
  logic              turnout;
  logic signed [10:0] speed_value;
  logic              percent_mode;
  logic [9:0]        speed_max;
  logic              light_on;
  logic              reverse_request;
  logic              direction;
  logic [3:0]        function_bits;
  logic              power_on;

  modport source (
    output valid, op, address, port, turnout, speed_value, percent_mode, speed_max,
           light_on, reverse_request, direction, function_bits, power_on,
    input  ready
  );

  modport sink (
    input  valid, op, address, port, turnout, speed_value, percent_mode, speed_max,
           light_on, reverse_request, direction, function_bits, power_on,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/rcbe_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcbe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_byte;
  logic       last_byte;

  modport source (
    output valid, command_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, command_byte, last_byte,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/rcbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/rcbe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbe_datapath
  import rcbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  output dp_stat_t               stat,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        address,
  input  wire logic [2:0]        port,
  input  wire logic              turnout,
  input  wire logic signed [10:0] speed_value,
  input  wire logic              percent_mode,
  input  wire logic [9:0]        speed_max,
  input  wire logic              light_on,
  input  wire logic              reverse_request,
  input  wire logic              direction,
  input  wire logic [3:0]        function_bits,
  input  wire logic              power_on,
  output logic [7:0]             command_byte
);

  // Captured command
  op_t        op_q;
  logic [7:0] addr_q;
  logic [2:0] port_q;
  logic       turnout_q;
  logic       light_q;
  logic       rev_q;
  logic       dir_q;
  logic [3:0] fbits_q;
  logic       pwr_q;

  // Divider
  logic [13:0] num;
  logic [9:0]  dvs_in;
  logic        dzero_in;
  logic [13:0] rem;
  logic [9:0]  dvs;
  logic        dzero;
  logic [3:0]  quo;
  logic [2:0]  div_cnt;
  logic [1:0]  bit_idx;
  logic [13:0] trial;
  logic [13:0] d15;

  // Direction store
  logic [LOCO_IDX_W-1:0] loco_idx;
  logic [LOCO_COUNT-1:0] dir_valid;
  logic                  ram_rd;
  logic                  stored_dir;
  logic [7:0]            sw_addr;

  // Scaled numerator: v*14, zero for negative or missing speed
  always_comb begin
    num      = speed_value[10] ? 14'd0
             : ({speed_value[9:0], 4'b0000} - {3'b000, speed_value[9:0], 1'b0});
    dvs_in   = percent_mode ? PERCENT_FULL : speed_max;
    dzero_in = !percent_mode && (speed_max == 10'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op_t'(op);
      addr_q    <= address;
      port_q    <= port;
      turnout_q <= turnout;
      light_q   <= light_on;
      rev_q     <= reverse_request;
      dir_q     <= direction;
      fbits_q   <= function_bits;
      pwr_q     <= power_on;
    end
  end

  // Saturation check first, then one quotient bit per cycle
  assign bit_idx = 2'(div_cnt - 3'd1);
  assign trial   = {4'b0000, dvs} << bit_idx;
  assign d15     = {dvs, 4'b0000} - {4'b0000, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 3'd0;
    end else if (cmd.load) begin
      div_cnt <= 3'd5;
    end else if (div_cnt == 3'd5) begin
      if (dzero || rem >= d15) begin
        div_cnt <= 3'd0;
      end else begin
        div_cnt <= 3'd4;
      end
    end else if (div_cnt != 3'd0) begin
      div_cnt <= div_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= num;
      dvs   <= dvs_in;
      dzero <= dzero_in;
    end else if (div_cnt == 3'd5) begin
      if (dzero) begin
        quo <= 4'd0;
      end else if (rem >= d15) begin
        quo <= SPEED_MAX_STEP;
      end else begin
        quo <= 4'd0;
      end
    end else if (div_cnt != 3'd0) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        quo <= quo | (4'b0001 << bit_idx);
      end
    end
  end

  // Direction bits: RAM plus per-entry valid flags (unwritten reads as one)
  assign loco_idx   = addr_q[LOCO_IDX_W-1:0];
  assign stored_dir = dir_valid[loco_idx] ? ram_rd : 1'b1;

  rcbe_ram #(
    .WIDTH (1),
    .DEPTH (LOCO_COUNT)
  ) u_dir_ram (
    .clk   (clk),
    .we    (cmd.toggle),
    .waddr (loco_idx),
    .wdata (!stored_dir),
    .raddr (loco_idx),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_valid <= '0;
    end else if (cmd.toggle) begin
      dir_valid[loco_idx] <= 1'b1;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.op       = op_q;
    stat.drop     = ((op_q == OP_SWITCH) && (addr_q == 8'd0))
                 || ((op_q == OP_LOCO) && ({1'b0, addr_q} >= LOCO_LIMIT));
    stat.need_rev = rev_q || (stored_dir != dir_q);
    stat.div_done = (div_cnt == 3'd0);
  end

  // Output byte select
  assign sw_addr = {6'(addr_q - 8'd1), 2'b00} + {5'b00000, port_q};

  always_comb begin
    case (cmd.sel)
      SEL_SWITCH_CODE: command_byte = turnout_q ? 8'd34 : 8'd33;
      SEL_SWITCH_ADDR: command_byte = sw_addr;
      SEL_STOP:        command_byte = {3'b000, light_q, 4'd0};
      SEL_REVERSE:     command_byte = {3'b000, light_q, 4'd15};
      SEL_SPEED:       command_byte = {3'b000, light_q, quo};
      SEL_ADDR:        command_byte = addr_q;
      SEL_FUNCTION:    command_byte = {4'b0100, fbits_q};
      SEL_POWER:       command_byte = pwr_q ? 8'd96 : 8'd97;
      default:         command_byte = addr_q;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/rcbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbe_ctrl
  import rcbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic          out_last,
  output ctrl_cmd_t     cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_SEND
  } state_t;

  typedef enum logic [2:0] {
    K_SWITCH,
    K_LOCO,
    K_LOCO_REV,
    K_FUNCTION,
    K_POWER
  } kind_t;

  state_t     state;
  kind_t      kind;
  kind_t      kind_next;
  logic [2:0] step;
  byte_sel_t  sel;
  logic       last;

  assign in_ready = (state == S_IDLE);

  // Byte sequence per command kind
  always_comb begin
    sel  = SEL_ADDR;
    last = 1'b0;
    case (kind)
      K_SWITCH: begin
        sel  = (step == 3'd0) ? SEL_SWITCH_CODE : SEL_SWITCH_ADDR;
        last = (step != 3'd0);
      end
      K_LOCO: begin
        sel  = (step == 3'd0) ? SEL_SPEED : SEL_ADDR;
        last = (step != 3'd0);
      end
      K_LOCO_REV: begin
        case (step)
          3'd0:    sel = SEL_STOP;
          3'd2:    sel = SEL_REVERSE;
          3'd4:    sel = SEL_SPEED;
          default: sel = SEL_ADDR;
        endcase
        last = (step == 3'd5);
      end
      K_FUNCTION: begin
        sel  = (step == 3'd0) ? SEL_FUNCTION : SEL_ADDR;
        last = (step != 3'd0);
      end
      K_POWER: begin
        sel  = SEL_POWER;
        last = 1'b1;
      end
      default: begin
        sel  = SEL_ADDR;
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (stat.op)
      OP_SWITCH:   kind_next = K_SWITCH;
      OP_LOCO:     kind_next = stat.need_rev ? K_LOCO_REV : K_LOCO;
      OP_FUNCTION: kind_next = K_FUNCTION;
      OP_POWER:    kind_next = K_POWER;
      default:     kind_next = K_POWER;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.toggle = (state == S_WAIT) && stat.div_done && !stat.drop
              && (stat.op == OP_LOCO) && stat.need_rev;
    cmd.sel    = sel;
  end

  assign out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_POWER;
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (stat.div_done) begin
            if (stat.drop) begin
              state <= S_IDLE;
            end else begin
              kind      <= kind_next;
              step      <= 3'd0;
              out_valid <= 1'b1;
              state     <= S_SEND;
            end
          end
        end
        S_SEND: begin
          if (out_ready) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              step <= step + 3'd1;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/rail_command_byte_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial command encoder for a classic model-railway interface. Each command
// item on the command channel becomes zero to six bytes on the result channel,
// the final one flagged with last_byte. One command is handled at a time: the
// block takes the item, waits for the loco speed divider (a saturation check,
// then one quotient bit per cycle), then sends one byte per cycle while the
// result side is ready, and returns to accept the next item. Switch commands to
// module 0 and loco commands at or above the direction store size produce no
// bytes. The per-loco direction bits start as ones after reset.
module rail_command_byte_encoder
  import rcbe_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rcbe_cmd_if.sink     command,
  rcbe_byte_if.source  result
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rcbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (command.valid),
    .in_ready  (command.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_last  (result.last_byte),
    .cmd       (cmd),
    .stat      (stat)
  );

  rcbe_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (command.op),
    .address         (command.address),
    .port            (command.port),
    .turnout         (command.turnout),
    .speed_value     (command.speed_value),
    .percent_mode    (command.percent_mode),
    .speed_max       (command.speed_max),
    .light_on        (command.light_on),
    .reverse_request (command.reverse_request),
    .direction       (command.direction),
    .function_bits   (command.function_bits),
    .power_on        (command.power_on),
    .command_byte    (result.command_byte)
  );

endmodule

`default_nettype wire

>>> tb/rail_command_byte_encoder_tb.sv
`timescale 1ns / 1ps

module rail_command_byte_encoder_tb;
  import rcbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 230;
  localparam int SETTLE_CYCLES = 40;

  // Byte codes on the serial link
  localparam logic [7:0] CODE_STRAIGHT = 8'd33;
  localparam logic [7:0] CODE_TURNOUT = 8'd34;
  localparam logic [7:0] CODE_REVERSE = 8'd15;
  localparam logic [7:0] CODE_LIGHT = 8'd16;
  localparam logic [7:0] CODE_FUNCTION = 8'd64;
  localparam logic [7:0] CODE_GO = 8'd96;
  localparam logic [7:0] CODE_STOP = 8'd97;

  typedef struct {
    op_t                op;
    logic [7:0]         address;
    logic [2:0]         port;
    logic               turnout;
    logic signed [10:0] speed_value;
    logic               percent_mode;
    logic [9:0]         speed_max;
    logic               light_on;
    logic               reverse_request;
    logic               direction;
    logic [3:0]         function_bits;
    logic               power_on;
  } cmd_item_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } byte_exp_t;

  // Predicts the byte stream of each command and checks the bytes that come out
  class cmd_byte_scoreboard;
    bit        loco_dir [LOCO_COUNT];
    byte_exp_t pending_bytes[$];
    int        errors;

    function new();
      foreach (loco_dir[i]) loco_dir[i] = 1'b1;
      errors = 0;
    endfunction

    function void push_byte(logic [7:0] code, logic last);
      byte_exp_t e;
      e.code = code;
      e.last = last;
      pending_bytes.push_back(e);
    endfunction

    // Speed step 0..14; negative values (not given included) give 0
    function logic [7:0] speed_step(cmd_item_t c);
      int unsigned mag;
      int unsigned q;
      if (c.speed_value[10]) return 8'd0;
      mag = c.speed_value[9:0];
      if (c.percent_mode) q = (mag * SPEED_MAX_STEP) / PERCENT_FULL;
      else if (c.speed_max != 0) q = (mag * SPEED_MAX_STEP) / c.speed_max;
      else q = 0;
      if (q > SPEED_MAX_STEP) q = SPEED_MAX_STEP;
      return 8'(q);
    endfunction

    function void note_command(cmd_item_t c);
      int          sum;
      logic [7:0]  lt;
      logic [7:0]  spd;
      case (c.op)
        OP_SWITCH: begin
          if (c.address != 0) begin
            push_byte(c.turnout ? CODE_TURNOUT : CODE_STRAIGHT, 1'b0);
            sum = (int'(c.address) - 1) * 4 + int'(c.port);
            push_byte(8'(sum), 1'b1);
          end
        end
        OP_LOCO: begin
          if (int'(c.address) < LOCO_COUNT) begin
            lt = c.light_on ? CODE_LIGHT : 8'd0;
            spd = speed_step(c);
            // direction change: stop, reverse, then the new speed
            if (c.reverse_request || loco_dir[c.address] != c.direction) begin
              push_byte(lt, 1'b0);
              push_byte(c.address, 1'b0);
              push_byte(CODE_REVERSE + lt, 1'b0);
              push_byte(c.address, 1'b0);
              loco_dir[c.address] = !loco_dir[c.address];
            end
            push_byte(spd + lt, 1'b0);
            push_byte(c.address, 1'b1);
          end
        end
        OP_FUNCTION: begin
          push_byte(CODE_FUNCTION + 8'(c.function_bits), 1'b0);
          push_byte(c.address, 1'b1);
        end
        default: begin
          push_byte(c.power_on ? CODE_GO : CODE_STOP, 1'b1);
        end
      endcase
    endfunction

    function void check_byte(logic [7:0] code, logic last);
      byte_exp_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t ERROR unexpected byte: expected none, actual byte %0d last %0b",
                 $time, code, last);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      if (code !== e.code) begin
        $display("%0t ERROR command_byte: expected %0d, actual %0d", $time, e.code, code);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t ERROR last_byte: expected %0b, actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rcbe_cmd_if  cmd_ch ();
  rcbe_byte_if byte_ch ();

  rail_command_byte_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_ch),
    .result  (byte_ch)
  );

  cmd_byte_scoreboard board;
  int         quiet_cycles = 0;
  logic [7:0] rx_tick = 8'd0;
  logic [15:0] rx_mask = 16'hFFFF;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: a quarter of the time always ready, otherwise a rerolled stall mask
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) rx_mask <= 16'($urandom) | 16'h0001;
    if (rx_tick[7:6] == 2'b11) byte_ch.ready <= 1'b1;
    else byte_ch.ready <= rx_mask[rx_tick[3:0]];
  end

  // Sample both channels mid-cycle, where everything is settled for the next edge
  always @(negedge clk) begin
    cmd_item_t c;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.op = op_t'(cmd_ch.op);
        c.address = cmd_ch.address;
        c.port = cmd_ch.port;
        c.turnout = cmd_ch.turnout;
        c.speed_value = cmd_ch.speed_value;
        c.percent_mode = cmd_ch.percent_mode;
        c.speed_max = cmd_ch.speed_max;
        c.light_on = cmd_ch.light_on;
        c.reverse_request = cmd_ch.reverse_request;
        c.direction = cmd_ch.direction;
        c.function_bits = cmd_ch.function_bits;
        c.power_on = cmd_ch.power_on;
        board.note_command(c);
      end
      if (byte_ch.valid && byte_ch.ready)
        board.check_byte(byte_ch.command_byte, byte_ch.last_byte);
      if ((cmd_ch.valid && cmd_ch.ready) || (byte_ch.valid && byte_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Present one item and hold it until taken; returns in the step of the accepting edge
  task automatic send_cmd(input cmd_item_t c);
    cmd_ch.valid <= 1'b1;
    cmd_ch.op <= c.op;
    cmd_ch.address <= c.address;
    cmd_ch.port <= c.port;
    cmd_ch.turnout <= c.turnout;
    cmd_ch.speed_value <= c.speed_value;
    cmd_ch.percent_mode <= c.percent_mode;
    cmd_ch.speed_max <= c.speed_max;
    cmd_ch.light_on <= c.light_on;
    cmd_ch.reverse_request <= c.reverse_request;
    cmd_ch.direction <= c.direction;
    cmd_ch.function_bits <= c.function_bits;
    cmd_ch.power_on <= c.power_on;
    @(negedge clk);
    while (!cmd_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold the sender off until every predicted byte has come out
  task automatic drain_bytes();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic cmd_item_t blank_item(op_t op);
    cmd_item_t c;
    c.op = op;
    c.address = 8'd0;
    c.port = 3'd0;
    c.turnout = 1'b0;
    c.speed_value = 11'sd0;
    c.percent_mode = 1'b0;
    c.speed_max = 10'd0;
    c.light_on = 1'b0;
    c.reverse_request = 1'b0;
    c.direction = 1'b0;
    c.function_bits = 4'd0;
    c.power_on = 1'b0;
    return c;
  endfunction

  function automatic cmd_item_t switch_item(logic [7:0] addr, logic [2:0] pin, logic turn);
    cmd_item_t c;
    c = blank_item(OP_SWITCH);
    c.address = addr;
    c.port = pin;
    c.turnout = turn;
    return c;
  endfunction

  function automatic cmd_item_t loco_item(logic [7:0] addr, logic signed [10:0] spd,
                                          logic pct, logic [9:0] vmax, logic light,
                                          logic rev, logic dir);
    cmd_item_t c;
    c = blank_item(OP_LOCO);
    c.address = addr;
    c.speed_value = spd;
    c.percent_mode = pct;
    c.speed_max = vmax;
    c.light_on = light;
    c.reverse_request = rev;
    c.direction = dir;
    return c;
  endfunction

  function automatic cmd_item_t func_item(logic [7:0] addr, logic [3:0] bits);
    cmd_item_t c;
    c = blank_item(OP_FUNCTION);
    c.address = addr;
    c.function_bits = bits;
    return c;
  endfunction

  function automatic cmd_item_t power_item(logic on);
    cmd_item_t c;
    c = blank_item(OP_POWER);
    c.power_on = on;
    return c;
  endfunction

  // Random command: all fields noise, then the fields that matter shaped per kind
  function automatic cmd_item_t rand_command();
    cmd_item_t   c;
    int unsigned pick;
    c.address = 8'($urandom);
    c.port = 3'($urandom);
    c.turnout = 1'($urandom);
    c.speed_value = 11'($urandom);
    c.percent_mode = 1'($urandom);
    c.speed_max = 10'($urandom);
    c.light_on = 1'($urandom);
    c.reverse_request = 1'($urandom);
    c.direction = 1'($urandom);
    c.function_bits = 4'($urandom);
    c.power_on = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) c.op = OP_LOCO;
    else if (pick < 65) c.op = OP_SWITCH;
    else if (pick < 85) c.op = OP_FUNCTION;
    else c.op = OP_POWER;
    case (c.op)
      OP_SWITCH: begin
        if ($urandom_range(0, 9) != 0) c.port = 3'($urandom_range(1, 4));
        if ($urandom_range(0, 15) == 0) c.address = 8'd0;
      end
      OP_LOCO: begin
        // a few locos get most commands so the direction bits see many toggles
        pick = $urandom_range(0, 9);
        if (pick < 5) c.address = 8'($urandom_range(0, 7));
        else if (pick < 9) c.address = 8'($urandom_range(0, LOCO_COUNT - 1));
        c.reverse_request = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) c.speed_value = -11'sd1;
        else if (pick > 1) c.speed_value = 11'($urandom_range(0, 1023));
        pick = $urandom_range(0, 9);
        if (pick == 0) c.speed_max = 10'd0;
        else if (pick < 4) c.speed_max = 10'($urandom_range(1, 40));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int burst_left;
    int gap;
    int n;
    board = new();
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_SWITCH;
    cmd_ch.address = 8'd0;
    cmd_ch.port = 3'd0;
    cmd_ch.turnout = 1'b0;
    cmd_ch.speed_value = 11'sd0;
    cmd_ch.percent_mode = 1'b0;
    cmd_ch.speed_max = 10'd0;
    cmd_ch.light_on = 1'b0;
    cmd_ch.reverse_request = 1'b0;
    cmd_ch.direction = 1'b0;
    cmd_ch.function_bits = 4'd0;
    cmd_ch.power_on = 1'b0;
    byte_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: switch module zero, address wrap, port outside 1..4
    send_cmd(switch_item(8'd0, 3'd1, 1'b0));
    send_cmd(switch_item(8'd1, 3'd1, 1'b0));
    send_cmd(switch_item(8'd255, 3'd4, 1'b1));
    send_cmd(switch_item(8'd64, 3'd7, 1'b1));
    send_cmd(switch_item(8'd2, 3'd0, 1'b0));
    // loco: speed not given, saturation, unusable maximum, out-of-range address
    send_cmd(loco_item(8'd0, -11'sd1, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1));
    send_cmd(loco_item(8'd0, 11'sd1023, 1'b1, 10'd0, 1'b1, 1'b0, 1'b0));
    send_cmd(loco_item(8'd80, 11'sd50, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1));
    send_cmd(loco_item(8'd81, 11'sd10, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1));
    send_cmd(loco_item(8'd255, 11'sd10, 1'b1, 10'd0, 1'b1, 1'b1, 1'b0));
    // forced reverse, then negative speeds other than not-given
    send_cmd(loco_item(8'd3, 11'sd100, 1'b0, 10'd100, 1'b0, 1'b1, 1'b1));
    send_cmd(loco_item(8'd3, -11'sd1024, 1'b0, 10'd5, 1'b1, 1'b0, 1'b0));
    send_cmd(loco_item(8'd5, -11'sd5, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1));
    send_cmd(loco_item(8'd6, 11'sd1023, 1'b0, 10'd1023, 1'b0, 1'b0, 1'b1));
    send_cmd(loco_item(8'd6, 11'sd73, 1'b0, 10'd1, 1'b1, 1'b0, 1'b1));
    send_cmd(loco_item(8'd7, 11'sd50, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1));
    // function addresses unchecked, power both ways
    send_cmd(func_item(8'd0, 4'd0));
    send_cmd(func_item(8'd255, 4'd15));
    send_cmd(func_item(8'd40, 4'b1010));
    send_cmd(power_item(1'b1));
    send_cmd(power_item(1'b0));
    drain_bytes();

    // Random commands in bursts; a middle stretch runs without gaps
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = (n >= 80 && n < 130) ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          cmd_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (n == RANDOM_ITEMS / 2) drain_bytes();
      send_cmd(rand_command());
      burst_left--;
    end

    drain_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rcbe_pkg.sv
hdl/rcbe_cmd_if.sv
hdl/rcbe_byte_if.sv
hdl/rcbe_ram.sv
hdl/rcbe_datapath.sv
hdl/rcbe_ctrl.sv
hdl/rail_command_byte_encoder.sv
tb/rail_command_byte_encoder_tb.sv
